// ===== rtl/rsmc_pkg.sv =====
// rsmc_pkg: shared widths, reset values, codes and the arctangent table of the ray caster.
// No dependencies; every other file of the block uses it.
`default_nettype none

package rsmc_pkg;

  // Build-time defaults for the top-level parameters
  localparam int MAX_SEGMENTS_DEF    = 256;
  localparam int TRIG_TABLE_BITS_DEF = 10;

  // Field widths
  localparam int COORD_W    = 32;
  localparam int SLOT_W     = 8;
  localparam int ANG_W      = 16;
  localparam int STEP_W     = 10;
  localparam int RANGE_W    = 31;
  localparam int ACT_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int SEG_W = 4 * COORD_W;   // one stored wall: {end_y, end_x, start_y, start_x}
  localparam int OPW   = 40;            // multiplier operand, covers every coordinate difference
  localparam int PW    = 2 * OPW;       // product and cross-product width
  localparam int DW    = PW + 2;        // divider remainder width
  localparam int CRW   = 34;            // CORDIC x, y and angle accumulators

  localparam int CORDIC_ITERS = 30;
  localparam int SCALE_SHIFT  = 30;
  localparam logic signed [CRW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [PW-1:0]  SCALE_HALF  = 80'sd536870912;

  // Register reset values
  localparam logic [ANG_W-1:0]          ANGLE_STEP_RST    = 16'd182;
  localparam logic signed [COORD_W-1:0] SENSOR_OFFSET_RST = 32'sd0;
  localparam logic [RANGE_W-1:0]        MAX_RANGE_RST     = 31'd655360;
  localparam logic [ACT_W-1:0]          ACTIVE_SEG_RST    = 9'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_STEP    = 2'd0,
    CFG_SENSOR_OFFSET = 2'd1,
    CFG_MAX_RANGE     = 2'd2,
    CFG_ACTIVE_SEGS   = 2'd3
  } cfg_reg_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  // Arctangent of 2^-i, 2^32 per full turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rsmc_if.sv =====
// rsmc_cmd_if and rsmc_res_if: valid/ready channels carrying command and result items.
// Depends on rsmc_pkg for field widths.
`default_nettype none

interface rsmc_cmd_if;
  import rsmc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [SLOT_W-1:0]         seg_slot;
  logic signed [COORD_W-1:0] wall_start_x;
  logic signed [COORD_W-1:0] wall_start_y;
  logic signed [COORD_W-1:0] wall_end_x;
  logic signed [COORD_W-1:0] wall_end_y;
  logic signed [COORD_W-1:0] pose_x;
  logic signed [COORD_W-1:0] pose_y;
  logic [ANG_W-1:0]          pose_heading;
  logic [STEP_W-1:0]         ray_step;

  modport source (output valid, opcode, seg_slot, wall_start_x, wall_start_y, wall_end_x,
                  wall_end_y, pose_x, pose_y, pose_heading, ray_step, input ready);
  modport sink   (input valid, opcode, seg_slot, wall_start_x, wall_start_y, wall_end_x,
                  wall_end_y, pose_x, pose_y, pose_heading, ray_step, output ready);
endinterface

interface rsmc_res_if;
  import rsmc_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [RANGE_W-1:0] range;

  modport source (output valid, hit, range, input ready);
  modport sink   (input valid, hit, range, output ready);
endinterface

`default_nettype wire

// ===== rtl/rsmc_ram.sv =====
// rsmc_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies beyond rsmc_pkg defaults.
`default_nettype none

module rsmc_ram #(
  parameter int  WIDTH = rsmc_pkg::SEG_W,
  parameter int  DEPTH = rsmc_pkg::MAX_SEGMENTS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsmc_mul.sv =====
// rsmc_mul: two-stage pipelined signed multiplier, one half-width partial product per stage.
// Depends on rsmc_pkg for the default operand width.
`default_nettype none

module rsmc_mul #(
  parameter int W = rsmc_pkg::OPW
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int HW = W / 2;

  logic signed [W-1:0]      a_r;
  logic signed [W-HW-1:0]   bh_r;
  logic signed [W+HW:0]     plo;
  logic signed [W+HW:0]     plo_r;
  logic signed [2*W-HW-1:0] phi;

  // low half of b as a non-negative operand
  assign plo = a * signed'({1'b0, b[HW-1:0]});
  assign phi = a_r * bh_r;

  always_ff @(posedge clk) begin
    a_r   <= a;
    bh_r  <= b[W-1:HW];
    plo_r <= plo;
    p     <= (2*W)'(plo_r) + ((2*W)'(phi) <<< HW);
  end

endmodule

`default_nettype wire

// ===== rtl/ray_segment_map_caster.sv =====
// ray_segment_map_caster: casts one ray against a stored wall map, one result per cast.
// A cast runs from command transfer to result valid through two 30-step CORDIC passes, the
// scaling of the sensor offset and ray length, then per tested wall one RAM read plus 12
// products through the shared two-stage multiplier, the range divider for a wall passing
// all crossing tests, and the final DONE state. The next command is taken once the result
// has loaded and the sequencer is back in IDLE; a load gives no result. Reset (rst, synchronous)
// clears control and restores register defaults; the wall RAM is not cleared.
// Depends on rsmc_pkg, rsmc_if, rsmc_ram and rsmc_mul.
`default_nettype none

module ray_segment_map_caster #(
  parameter int MAX_SEGMENTS    = rsmc_pkg::MAX_SEGMENTS_DEF,
  parameter int TRIG_TABLE_BITS = rsmc_pkg::TRIG_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  rsmc_cmd_if.sink                         cmd,
  rsmc_res_if.source                       res,
  input  logic                             cfg_we,
  input  logic [rsmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import rsmc_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int KW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;

  // Sequencer: IDLE -> TRIG (two CORDIC passes) -> SCALE -> per wall SEGF/SEGM[/DIV] -> DONE
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TRIG  = 7'b0000010,
    ST_SCALE = 7'b0000100,
    ST_SEGF  = 7'b0001000,
    ST_SEGM  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic                  flip;
    logic signed [CRW-1:0] z;
  } seed_t;

  state_t state;

  // Configuration registers
  logic [ANG_W-1:0]          angle_step;
  logic signed [COORD_W-1:0] sensor_offset;
  logic [RANGE_W-1:0]        ray_len;
  logic [ACT_W-1:0]          active_segments;

  // Ray geometry
  logic signed [OPW-1:0] px, py, ox, oy, ex, ey, dxr, dyr;
  logic [ANG_W-1:0]      ray_ang;

  // CORDIC
  logic signed [CRW-1:0] cx, cy, cz, ch, sh, cr, sr;
  logic signed [CRW-1:0] nx, ny, nz, dxs, dys, atn;
  logic                  cflip, tp;
  logic [4:0]            it;
  seed_t                 seed_head, seed_ray;

  // Phase and wall counters
  logic [3:0]    ph;
  logic [3:0]    pj;
  logic [KW-1:0] k, n_seg;

  // Wall RAM
  logic             ram_we, ram_re, slot_ok;
  logic [SW-1:0]    slot_w;
  logic [AW-1:0]    ram_waddr;
  logic [SEG_W-1:0] ram_wdata, ram_rdata;

  // Multiplier
  logic signed [OPW-1:0] ma, mb, rnd;
  logic signed [PW-1:0]  mp, rsum, rsc;

  // Per-wall cross products: 0..3 orientations, 4 determinant, 5 numerator
  logic signed [PW-1:0] xr [6];
  logic signed [PW-1:0] plast;

  logic signed [OPW-1:0] sxe, sye, fxe, fye, wxe, wye;
  logic signed [OPW-1:0] rminx, rmaxx, rminy, rmaxy;
  logic signed [PW-1:0]  dn, nm;
  logic                  bb_rej, eq01, eq23, cand;

  // Range divider
  logic [DW-1:0]      dv_den, dv_num, rem, r2, den2, remn;
  logic [31:0]        q, qn;
  logic [4:0]         bc;
  logic               bitm;

  // Best hit and result register
  logic               bhit;
  logic [RANGE_W-1:0] best;
  logic               res_valid, res_hit, out_free;
  logic [RANGE_W-1:0] res_range;

  // Fold a heading into the CORDIC range: cut to the table resolution, flip the back half.
  function automatic seed_t fold(input logic [ANG_W-1:0] ang);
    logic [31:0] a;
    seed_t       s;
    a = {ang[ANG_W-1 -: TRIG_TABLE_BITS], {(32-TRIG_TABLE_BITS){1'b0}}};
    s.flip = a[31] ^ a[30];
    if (s.flip) begin
      a[31] = ~a[31];
    end
    s.z = CRW'(signed'(a));
    return s;
  endfunction

  assign seed_head = fold(cmd.pose_heading);
  assign seed_ray  = fold(ray_ang);

  // ---------------------------------------------------------------------------
  // Configuration port: a write takes effect at the edge where it is presented.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_step      <= ANGLE_STEP_RST;
      sensor_offset   <= SENSOR_OFFSET_RST;
      ray_len         <= MAX_RANGE_RST;
      active_segments <= ACTIVE_SEG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_STEP:    angle_step      <= cfg_data[ANG_W-1:0];
        CFG_SENSOR_OFFSET: sensor_offset   <= signed'(cfg_data[COORD_W-1:0]);
        CFG_MAX_RANGE:     ray_len         <= cfg_data[RANGE_W-1:0];
        CFG_ACTIVE_SEGS:   active_segments <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Walls beyond the store are never tested.
  always_comb begin
    if (32'(active_segments) >= MAX_SEGMENTS) begin
      n_seg = KW'(MAX_SEGMENTS);
    end else begin
      n_seg = KW'(active_segments);
    end
  end

  // ---------------------------------------------------------------------------
  // Wall store. Loads only happen in IDLE and reads only during a cast, so a read
  // and a write to the same entry never overlap and no forwarding is needed.
  // ---------------------------------------------------------------------------
  assign slot_ok   = 32'(cmd.seg_slot) < MAX_SEGMENTS;
  assign slot_w    = SW'(cmd.seg_slot);
  assign ram_waddr = slot_w[AW-1:0];
  assign ram_wdata = {cmd.wall_end_y, cmd.wall_end_x, cmd.wall_start_y, cmd.wall_start_x};
  assign ram_we    = cmd.valid && cmd.ready && (cmd.opcode == OP_LOAD) && slot_ok;
  assign ram_re    = (state == ST_SEGF) && (k < n_seg);

  rsmc_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_wall_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (k[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // CORDIC iteration, one micro-rotation per cycle.
  // ---------------------------------------------------------------------------
  always_comb begin
    dxs = cy >>> it;
    dys = cx >>> it;
    atn = CRW'(atan_turn(it));
    if (!cz[CRW-1]) begin
      nx = cx - dxs;
      ny = cy + dys;
      nz = cz - atn;
    end else begin
      nx = cx + dxs;
      ny = cy - dys;
      nz = cz + atn;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: operands are chosen by state and phase; the product comes back
  // through the multiplier's pipeline registers, so results are picked up by the lagged phase pj.
  // ---------------------------------------------------------------------------
  assign sxe = OPW'(signed'(ram_rdata[COORD_W-1:0]));
  assign sye = OPW'(signed'(ram_rdata[2*COORD_W-1:COORD_W]));
  assign fxe = OPW'(signed'(ram_rdata[3*COORD_W-1:2*COORD_W]));
  assign fye = OPW'(signed'(ram_rdata[4*COORD_W-1:3*COORD_W]));
  assign wxe = fxe - sxe;
  assign wye = fye - sye;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_SCALE: begin
        case (ph)
          4'd0: begin ma = OPW'(sensor_offset); mb = OPW'(ch); end
          4'd1: begin ma = OPW'(sensor_offset); mb = OPW'(sh); end
          4'd2: begin ma = OPW'(signed'({1'b0, ray_len})); mb = OPW'(cr); end
          4'd3: begin ma = OPW'(signed'({1'b0, ray_len})); mb = OPW'(sr); end
          default: ;
        endcase
      end
      ST_SEGM: begin
        case (ph)
          // ray orientation of the wall start and end
          4'd0:  begin ma = dyr;       mb = sxe - ex;  end
          4'd1:  begin ma = dxr;       mb = sye - ey;  end
          4'd2:  begin ma = dyr;       mb = fxe - ex;  end
          4'd3:  begin ma = dxr;       mb = fye - ey;  end
          // wall orientation of the ray origin and end
          4'd4:  begin ma = wye;       mb = ox - fxe;  end
          4'd5:  begin ma = wxe;       mb = oy - fye;  end
          4'd6:  begin ma = wye;       mb = ex - fxe;  end
          4'd7:  begin ma = wxe;       mb = ey - fye;  end
          // determinant and numerator of the crossing fraction
          4'd8:  begin ma = dxr;       mb = wye;       end
          4'd9:  begin ma = dyr;       mb = wxe;       end
          4'd10: begin ma = sxe - ox;  mb = wye;       end
          4'd11: begin ma = sye - oy;  mb = wxe;       end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  rsmc_mul #(
    .W (OPW)
  ) u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (mp)
  );

  // Q16.16 * Q2.30, rounded to Q16.16
  assign rsum = mp + SCALE_HALF;
  assign rsc  = rsum >>> SCALE_SHIFT;
  assign rnd  = signed'(rsc[OPW-1:0]);
  assign pj   = ph - 4'd2;

  // ---------------------------------------------------------------------------
  // Wall decision once all six cross products are in.
  // ---------------------------------------------------------------------------
  always_comb begin
    rminx = (ox < ex) ? ox : ex;
    rmaxx = (ox > ex) ? ox : ex;
    rminy = (oy < ey) ? oy : ey;
    rmaxy = (oy > ey) ? oy : ey;
    bb_rej = (rmaxx < ((sxe < fxe) ? sxe : fxe)) || (rminx > ((sxe > fxe) ? sxe : fxe)) ||
             (rmaxy < ((sye < fye) ? sye : fye)) || (rminy > ((sye > fye) ? sye : fye));
    // same sign, zero counting as its own sign
    eq01 = (xr[0][PW-1] == xr[1][PW-1]) && ((|xr[0]) == (|xr[1]));
    eq23 = (xr[2][PW-1] == xr[3][PW-1]) && ((|xr[2]) == (|xr[3]));
    dn   = xr[4][PW-1] ? -xr[4] : xr[4];
    nm   = xr[4][PW-1] ? -xr[5] : xr[5];
    cand = !bb_rej && !eq01 && !eq23 && (|xr[4]) && !nm[PW-1] && (nm < dn);
  end

  // ---------------------------------------------------------------------------
  // Range divider: floor(num * ray_len / den), one bit of ray_len per cycle.
  // The remainder stays below den, so each step subtracts den at most twice.
  // ---------------------------------------------------------------------------
  always_comb begin
    bitm = ray_len[bc];
    r2   = {rem[DW-2:0], 1'b0} + (bitm ? dv_num : '0);
    den2 = {dv_den[DW-2:0], 1'b0};
    if (r2 >= den2) begin
      remn = r2 - den2;
      qn   = {q[30:0], 1'b0} + 32'd2;
    end else if (r2 >= dv_den) begin
      remn = r2 - dv_den;
      qn   = {q[30:0], 1'b0} + 32'd1;
    end else begin
      remn = r2;
      qn   = {q[30:0], 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequencer and datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph    <= '0;
      k     <= '0;
      it    <= '0;
      tp    <= 1'b0;
      bc    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          // a load transfer is done by the RAM write alone; a cast starts the sequence
          if (cmd.valid && cmd.opcode == OP_CAST) begin
            px      <= OPW'(cmd.pose_x);
            py      <= OPW'(cmd.pose_y);
            ray_ang <= cmd.pose_heading + ANG_W'(cmd.ray_step * angle_step);
            cx      <= CORDIC_GAIN;
            cy      <= '0;
            cz      <= seed_head.z;
            cflip   <= seed_head.flip;
            it      <= '0;
            tp      <= 1'b0;
            bhit    <= 1'b0;
            best    <= '0;
            state   <= ST_TRIG;
          end
        end

        ST_TRIG: begin
          if (it == 5'(CORDIC_ITERS - 1) && !tp) begin
            ch    <= cflip ? -nx : nx;
            sh    <= cflip ? -ny : ny;
            // second pass on the ray heading
            cx    <= CORDIC_GAIN;
            cy    <= '0;
            cz    <= seed_ray.z;
            cflip <= seed_ray.flip;
            it    <= '0;
            tp    <= 1'b1;
          end else begin
            cx <= nx;
            cy <= ny;
            cz <= nz;
            it <= it + 5'd1;
            if (it == 5'(CORDIC_ITERS - 1)) begin
              cr    <= cflip ? -nx : nx;
              sr    <= cflip ? -ny : ny;
              ph    <= '0;
              state <= ST_SCALE;
            end
          end
        end

        ST_SCALE: begin
          ph <= ph + 4'd1;
          case (ph)
            4'd2: ox <= px + rnd;
            4'd3: oy <= py + rnd;
            4'd4: begin
              dxr <= rnd;
              ex  <= ox + rnd;
            end
            4'd5: begin
              dyr   <= rnd;
              ey    <= oy + rnd;
              k     <= '0;
              state <= ST_SEGF;
            end
            default: ;
          endcase
        end

        ST_SEGF: begin
          // read is issued here; the wall is on the RAM output from the next cycle
          ph <= '0;
          if (k < n_seg) begin
            state <= ST_SEGM;
          end else begin
            state <= ST_DONE;
          end
        end

        ST_SEGM: begin
          ph <= ph + 4'd1;
          if (ph >= 4'd2 && ph <= 4'd13) begin
            if (!pj[0]) begin
              plast <= mp;
            end else begin
              xr[pj[3:1]] <= plast - mp;
            end
          end
          if (ph == 4'd14) begin
            if (cand) begin
              dv_den <= DW'(unsigned'(dn));
              dv_num <= DW'(unsigned'(nm));
              rem    <= '0;
              q      <= '0;
              bc     <= 5'(RANGE_W - 1);
              state  <= ST_DIV;
            end else begin
              k     <= k + KW'(1);
              state <= ST_SEGF;
            end
          end
        end

        ST_DIV: begin
          rem <= remn;
          q   <= qn;
          bc  <= bc - 5'd1;
          if (bc == 5'd0) begin
            // keep the nearest hit
            if (!bhit || qn[RANGE_W-1:0] < best) begin
              best <= qn[RANGE_W-1:0];
              bhit <= 1'b1;
            end
            k     <= k + KW'(1);
            state <= ST_SEGF;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: holds the finished result until its transfer, while the
  // next cast is already being worked on.
  // ---------------------------------------------------------------------------
  assign out_free = !res_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      res_hit   <= bhit;
      res_range <= bhit ? best : '0;
    end
  end

  assign cmd.ready = (state == ST_IDLE);
  assign res.valid = res_valid;
  assign res.hit   = res_hit;
  assign res.range = res_range;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_miss_zero_range: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |-> res.range == '0)
    else $error("result without a hit carries a nonzero range");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < dv_den)
    else $error("divider remainder reached the divisor");

  a_wall_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEGM |-> k < n_seg)
    else $error("wall under test lies beyond the active count");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && (!res.valid || res.ready) |=> res.valid)
    else $error("finished cast did not reach the result register");

endmodule

`default_nettype wire

// ===== dv/rsmc_checker.sv =====
// rsmc_checker: watches the command, result and register ports of the ray caster,
// predicts every cast result and compares it field by field with what comes out.
// Depends on rsmc_pkg and on the channel interfaces in rsmc_if.
`default_nettype none

module rsmc_checker (
  input  logic                             clk,
  input  logic                             rst,
  rsmc_cmd_if                              cmd,
  rsmc_res_if                              res,
  input  logic                             cfg_we,
  input  logic [rsmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsmc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fails,
  output int                               pending,
  output int                               casts,
  output int                               hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsmc_pkg::*;

  localparam int WALLS     = MAX_SEGMENTS_DEF;
  localparam int TAB_BITS  = TRIG_TABLE_BITS_DEF;

  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    logic               hit;
    logic [RANGE_W-1:0] span;
  } echo_t;
  typedef struct {
    longint c;
    longint s;
  } dir_t;

  // Arctangent of 2^-i, one turn is 2^32
  localparam logic [31:0] ATAN [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  logic [ANG_W-1:0]   step_cfg;
  longint             offset_cfg;
  longint             reach_cfg;
  int                 walls_cfg;
  longint             wsx [WALLS];
  longint             wsy [WALLS];
  longint             wex [WALLS];
  longint             wey [WALLS];
  echo_t              echo_q [$];
  int                 n_fail, n_cast, n_hit;

  function automatic dir_t heading_vec(input logic [ANG_W-1:0] ang);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, dx, dy;
    dir_t        d;
    a    = 32'(ang >> (ANG_W - TAB_BITS)) << (32 - TAB_BITS);
    flip = 1'b0;
    if (a >= 32'h40000000 && a < 32'hC0000000) begin
      a    = a - 32'h80000000;
      flip = 1'b1;
    end
    z = longint'(signed'(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN[i]);
      end
    end
    d.c = flip ? -x : x;
    d.s = flip ? -y : y;
    return d;
  endfunction

  function automatic longint rescale(input longint v, input longint t);
    return (v * t + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic int side(input longint px, py, qx, qy, rx, ry);
    wide_t a;
    a = wide_t'(qy - py) * wide_t'(rx - qx) - wide_t'(qx - px) * wide_t'(ry - qy);
    return (a < 0) ? -1 : ((a != 0) ? 1 : 0);
  endfunction

  function automatic longint lo(input longint a, b);
    return a < b ? a : b;
  endfunction

  function automatic longint hi(input longint a, b);
    return a > b ? a : b;
  endfunction

  function automatic echo_t nearest_wall(input longint px, py,
                                         input logic [ANG_W-1:0] hd,
                                         input logic [STEP_W-1:0] st);
    dir_t         hv, rv;
    logic [31:0]  ang;
    longint       ox, oy, ex, ey, dxr, dyr, sx, sy, fx, fy, wx, wy;
    wide_t        num, den, q;
    int           n;
    echo_t        e;
    e   = '0;
    ang = 32'(hd) + 32'(st) * 32'(step_cfg);
    hv  = heading_vec(hd);
    rv  = heading_vec(ang[ANG_W-1:0]);
    ox  = px + rescale(offset_cfg, hv.c);
    oy  = py + rescale(offset_cfg, hv.s);
    dxr = rescale(reach_cfg, rv.c);
    dyr = rescale(reach_cfg, rv.s);
    ex  = ox + dxr;
    ey  = oy + dyr;
    n   = walls_cfg > WALLS ? WALLS : walls_cfg;
    for (int k = 0; k < n; k++) begin
      sx = wsx[k]; sy = wsy[k]; fx = wex[k]; fy = wey[k];
      wx = fx - sx; wy = fy - sy;
      if (hi(ox, ex) < lo(sx, fx) || lo(ox, ex) > hi(sx, fx) ||
          hi(oy, ey) < lo(sy, fy) || lo(oy, ey) > hi(sy, fy)) continue;
      if (side(ox, oy, ex, ey, sx, sy) == side(ox, oy, ex, ey, fx, fy)) continue;
      if (side(sx, sy, fx, fy, ox, oy) == side(sx, sy, fx, fy, ex, ey)) continue;
      den = wide_t'(dxr) * wide_t'(wy) - wide_t'(dyr) * wide_t'(wx);
      num = wide_t'(sx - ox) * wide_t'(wy) - wide_t'(sy - oy) * wide_t'(wx);
      if (den == 0) continue;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      if (num < 0 || num >= den) continue;
      q = (num * wide_t'(reach_cfg)) / den;
      if (!e.hit || q[RANGE_W-1:0] < e.span) begin
        e.hit  = 1'b1;
        e.span = q[RANGE_W-1:0];
      end
    end
    return e;
  endfunction

  always @(posedge clk) begin
    echo_t got, want;
    if (rst) begin
      step_cfg   = ANGLE_STEP_RST;
      offset_cfg = 0;
      reach_cfg  = longint'(MAX_RANGE_RST);
      walls_cfg  = int'(ACTIVE_SEG_RST);
      echo_q.delete();
      n_fail = 0; n_cast = 0; n_hit = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ANGLE_STEP:    step_cfg   = cfg_data[ANG_W-1:0];
          CFG_SENSOR_OFFSET: offset_cfg = longint'(signed'(cfg_data));
          CFG_MAX_RANGE:     reach_cfg  = longint'(cfg_data[RANGE_W-1:0]);
          CFG_ACTIVE_SEGS:   walls_cfg  = int'(cfg_data[ACT_W-1:0]);
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        if (cmd.opcode == OP_LOAD) begin
          wsx[cmd.seg_slot] = longint'(cmd.wall_start_x);
          wsy[cmd.seg_slot] = longint'(cmd.wall_start_y);
          wex[cmd.seg_slot] = longint'(cmd.wall_end_x);
          wey[cmd.seg_slot] = longint'(cmd.wall_end_y);
        end else begin
          echo_q = {echo_q, nearest_wall(longint'(cmd.pose_x), longint'(cmd.pose_y),
                                         cmd.pose_heading, cmd.ray_step)};
          n_cast++;
        end
      end
      if (res.valid && res.ready) begin
        got.hit  = res.hit;
        got.span = res.range;
        if (echo_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result with none expected: hit=%0b range=%0d",
                     $realtime, got.hit, got.span);
        end else begin
          want = echo_q.pop_front();
          if (want.hit) n_hit++;
          if (got.hit !== want.hit || got.span !== want.span) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: mismatch: expected hit=%0b range=%0d, got hit=%0b range=%0d",
                       $realtime, want.hit, want.span, got.hit, got.span);
          end
        end
      end
    end
    fails   <= n_fail;
    pending <= echo_q.size();
    casts   <= n_cast;
    hits    <= n_hit;
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: clock, reset and stimulus for the ray caster, with the checker beside it.
// Depends on rsmc_pkg, rsmc_if, the block's RTL and dv/rsmc_checker.sv.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rsmc_pkg::*;

  localparam longint METRE = 65536;
  localparam int     LIMIT = 12_000_000;
  // Worst cast: every wall tested and crossing
  localparam int     SETTLE = 69 + 47 * MAX_SEGMENTS_DEF;

  logic clk, rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fails, pending, casts, hits;
  int cycles = 0;

  // quiet: no idling on either side; hold_off: long receiver stall
  logic quiet, hold_off, press_go;
  bit   written [MAX_SEGMENTS_DEF];

  rsmc_cmd_if cmd ();
  rsmc_res_if res ();

  ray_segment_map_caster u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd.sink),
    .res       (res.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rsmc_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending),
    .casts     (casts),
    .hits      (hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up long after the slowest legal run would have ended
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random back-pressure, none in quiet stretches, full back-pressure while held off
  always @(posedge clk) begin
    res.ready <= !hold_off && (quiet || $urandom_range(99) >= 24);
  end

  // Long receiver stall, counted here so the sender keeps offering transfers meanwhile
  initial begin
    hold_off <= 1'b0;
    wait (press_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (4000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Drive one transfer and hold it until the block takes it
  task automatic offer(input logic op, input logic [SLOT_W-1:0] slot,
                       input longint a, b, c, d, px, py,
                       input logic [ANG_W-1:0] hd, input logic [STEP_W-1:0] st);
    if (!quiet && $urandom_range(99) < 24) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.opcode       <= op;
    cmd.seg_slot     <= slot;
    cmd.wall_start_x <= 32'(a);
    cmd.wall_start_y <= 32'(b);
    cmd.wall_end_x   <= 32'(c);
    cmd.wall_end_y   <= 32'(d);
    cmd.pose_x       <= 32'(px);
    cmd.pose_y       <= 32'(py);
    cmd.pose_heading <= hd;
    cmd.ray_step     <= st;
    do @(posedge clk); while (!cmd.ready);
  endtask

  // Loads carry random pose fields and casts random wall fields, so those bits toggle too
  task automatic load_wall(input int slot, input longint a, b, c, d);
    offer(OP_LOAD, SLOT_W'(slot), a, b, c, d, longint'(signed'($urandom())),
          longint'(signed'($urandom())), ANG_W'($urandom()), STEP_W'($urandom()));
    written[slot] = 1'b1;
  endtask

  task automatic cast_ray(input longint px, py, input int hd, st);
    offer(OP_CAST, SLOT_W'($urandom()), longint'(signed'($urandom())),
          longint'(signed'($urandom())), longint'(signed'($urandom())),
          longint'(signed'($urandom())), px, py, ANG_W'(hd), STEP_W'(st));
  endtask

  // Let everything drain, then write all four registers in consecutive cycles
  task automatic set_regs(input int step, input longint offs, reach, input int walls);
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ANGLE_STEP;
    cfg_data  <= 32'(step);
    @(posedge clk);
    cfg_index <= CFG_SENSOR_OFFSET;
    cfg_data  <= 32'(offs);
    @(posedge clk);
    cfg_index <= CFG_MAX_RANGE;
    cfg_data  <= 32'(reach);
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_SEGS;
    cfg_data  <= 32'(walls);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Slots 0..n-1 all loaded: the largest safe active count
  function automatic int loaded_run();
    int n;
    n = 0;
    while (n < MAX_SEGMENTS_DEF && written[n]) n++;
    return n;
  endfunction

  function automatic longint near(input longint c, input longint spread);
    longint v;
    v = c + longint'($urandom_range(32'(2 * spread))) - spread;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic longint any32();
    return longint'(signed'($urandom()));
  endfunction

  initial begin
    longint cx, cy, reach, offs;
    int     walls, step, n_items;
    rst       <= 1'b1;
    quiet     <= 1'b0;
    press_go  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ANGLE_STEP;
    cfg_data  <= '0;
    cmd.valid <= 1'b0;
    cmd.opcode <= OP_LOAD;
    cmd.seg_slot <= '0;
    cmd.wall_start_x <= '0;
    cmd.wall_start_y <= '0;
    cmd.wall_end_x <= '0;
    cmd.wall_end_y <= '0;
    cmd.pose_x <= '0;
    cmd.pose_y <= '0;
    cmd.pose_heading <= '0;
    cmd.ray_step <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a small hand-built map around the origin
    load_wall(0, 5 * METRE, -3 * METRE, 5 * METRE, 3 * METRE);      // square across the ray
    load_wall(1, 1 * METRE, 0, 8 * METRE, 0);                      // lies along the ray
    load_wall(2, 10 * METRE, -METRE, 10 * METRE, METRE);           // right at the ray end
    load_wall(3, 3 * METRE, 0, 3 * METRE, 2 * METRE);              // end touches the ray
    load_wall(4, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648);
    load_wall(255, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648, -64'sd2147483648);
    cast_ray(0, 0, 0, 0);                                          // no walls active yet
    set_regs(182, 0, 10 * METRE, 4);
    cast_ray(0, 0, 0, 0);
    cast_ray(0, 0, 16384, 0);
    cast_ray(0, 0, 32768, 0);
    cast_ray(0, 0, 49152, 0);
    cast_ray(0, 0, 65535, 1023);
    cast_ray(-4 * METRE, 0, 0, 0);
    set_regs(182, 0, 10 * METRE, 5);
    cast_ray(64'sd2147483647, -64'sd2147483648, 0, 1023);
    cast_ray(0, 0, 8192, 0);
    set_regs(65535, 64'sd2147483647, 0, 5);                        // zero-length ray
    cast_ray(0, 0, 0, 1023);
    set_regs(0, -64'sd2147483648, 64'sd2147483647, 5);
    cast_ray(0, 0, 0, 0);
    cast_ray(-64'sd2147483648, 64'sd2147483647, 40000, 517);

    // Random: phases of walls and rays clustered round a centre, with some noise
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: begin cx = 0; cy = 0; end
        1: begin cx = near(0, 64'sd2143289344); cy = near(0, 64'sd2143289344); end
        2: begin cx = 64'sd2145386496;  cy = 64'sd2145386496;  end
        default: begin cx = -64'sd2145386496; cy = -64'sd2145386496; end
      endcase
      step  = (ph == 1) ? 65535 : (ph == 3) ? 0 : int'($urandom_range(65535));
      offs  = (ph == 5) ? 64'sd2147483647 : (ph == 6) ? -64'sd2147483648
            : near(0, 3 * METRE);
      reach = (ph == 7) ? 0 : (ph == 8) ? 64'sd2147483647
            : longint'($urandom_range(32'(METRE), 32'(25 * METRE)));
      if (ph == 12) begin
        // Fill the whole store, then test every wall with a saturating count
        for (int k = 0; k < MAX_SEGMENTS_DEF; k++)
          load_wall(k, near(cx, 20 * METRE), near(cy, 20 * METRE),
                    near(cx, 20 * METRE), near(cy, 20 * METRE));
        set_regs(step, offs, reach, 511);
        for (int k = 0; k < 8; k++)
          cast_ray(near(cx, 5 * METRE), near(cy, 5 * METRE), $urandom(), $urandom());
        set_regs(step, offs, reach, MAX_SEGMENTS_DEF);
        for (int k = 0; k < 4; k++)
          cast_ray(near(cx, 5 * METRE), near(cy, 5 * METRE), $urandom(), $urandom());
        continue;
      end
      walls = loaded_run();
      if (walls > 24) walls = 24;
      walls = $urandom_range(walls);
      set_regs(step, offs, reach, walls);
      press_go <= (ph == 1);
      quiet    <= (ph == 2);
      n_items  = 0;
      while (n_items < 140) begin
        if ($urandom_range(99) < 30) begin
          if ($urandom_range(9) == 0)
            load_wall($urandom_range(255), any32(), any32(), any32(), any32());
          else
            load_wall($urandom_range(31), near(cx, 20 * METRE), near(cy, 20 * METRE),
                      near(cx, 20 * METRE), near(cy, 20 * METRE));
        end else if ($urandom_range(19) == 0) begin
          cast_ray(any32(), any32(), $urandom(), $urandom());
        end else begin
          cast_ray(near(cx, 5 * METRE), near(cy, 5 * METRE), $urandom(), $urandom());
        end
        n_items++;
      end
    end

    // Drain, then allow the block's own latency before the verdict
    cmd.valid <= 1'b0;
    quiet     <= 1'b1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    #1;
    $display("Cast %0d rays (%0d hitting a wall) over a changing wall map, with register",
             casts, hits);
    $display("extremes, a full 256-wall store and a long result stall; %0d mismatches.", fails);
    if (fails == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rsmc_pkg.sv
rtl/rsmc_if.sv
rtl/rsmc_ram.sv
rtl/rsmc_mul.sv
rtl/ray_segment_map_caster.sv
dv/rsmc_checker.sv
dv/tb_top.sv
